// ===== rtl/cd_audio_deemphasis_iir_core_assert.svh =====
// ----------------------------------------------------------------------------
// De-emphasis core assertion macros
// Concurrent assertion wrappers on clock and reset. Defining NO_ASSERTIONS
// turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef CD_AUDIO_DEEMPHASIS_IIR_CORE_ASSERT_SVH
`define CD_AUDIO_DEEMPHASIS_IIR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The expression holds at every clock edge outside reset.
`define CDDE_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// When the antecedent holds, the consequent holds in the next cycle.
`define CDDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CDDE_ASSERT_ALWAYS(label, expr, msg)
`define CDDE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/cdde_pkg.sv =====
// ----------------------------------------------------------------------------
// De-emphasis package
// Widths, fixed-point formats, coefficient defaults and register indexes
// shared by the de-emphasis core and its channel filter.
// ----------------------------------------------------------------------------
package cdde_pkg;

   // Field widths and fixed-point formats.
   localparam int SAMPLE_W        = 16;
   localparam int COEF_W          = 18;
   localparam int COEF_FRAC_BITS  = 16;
   localparam int STATE_FRAC_BITS = 8;
   localparam int Y1_W            = 26;

   // Accumulator widths for acc = (b0*x + b1*x1) * 2^STATE_FRAC_BITS - a1*y1.
   localparam int FF_W   = SAMPLE_W + COEF_W + 1;
   localparam int FFSH_W = FF_W + STATE_FRAC_BITS;
   localparam int FB_W   = COEF_W + Y1_W;
   localparam int ACC_W  = ((FFSH_W > FB_W) ? FFSH_W : FB_W) + 1;
   localparam int RND_W  = ACC_W + 1;
   localparam int YR_W   = RND_W - COEF_FRAC_BITS;
   localparam int OR_W   = RND_W - COEF_FRAC_BITS - STATE_FRAC_BITS;

   // Rounding offsets (half an LSB of the kept result).
   localparam logic [RND_W-1:0] Y_HALF = RND_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [RND_W-1:0] O_HALF =
      RND_W'(1) << (COEF_FRAC_BITS + STATE_FRAC_BITS - 1);

   // Saturation limits.
   localparam logic [Y1_W-1:0]     Y1_MAX = {1'b0, {(Y1_W-1){1'b1}}};
   localparam logic [Y1_W-1:0]     Y1_MIN = {1'b1, {(Y1_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Coefficient defaults: 50/15 us at 44.1 kHz, bilinear transform.
   localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd28141;
   localparam logic signed [COEF_W-1:0] B1_RESET = -18'sd3913;
   localparam logic signed [COEF_W-1:0] A1_RESET = -18'sd41308;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A1 = 2'd2;

   // Coefficient set handed to each channel filter.
   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] a1;
   } coef_set_type;

endpackage

// ===== rtl/cd_audio_deemphasis_iir_core.sv =====
// ----------------------------------------------------------------------------
// CD audio de-emphasis core
// Stereo first-order 50/15 us de-emphasis with pass-through for items
// whose section carries no pre-emphasis.
// ----------------------------------------------------------------------------
// The core accepts one stereo item per clock cycle while rsp_stall is low and
// returns its result through the input register and then the result register
// behind the filter. The rate is set by the per-channel feedback path (three
// multiplies, one accumulate, rounding and saturation), combinational between
// the state registers. An item with the emphasis flag clear is passed through
// unchanged; any change of the flag clears both channels' filter history.
// Coefficient writes take effect on the next item; the user is to make them
// only while the core is idle, which the core itself does not enforce.
`include "cd_audio_deemphasis_iir_core_assert.svh"

module cd_audio_deemphasis_iir_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cdde_pkg::SAMPLE_W-1:0]   req_left_in,
   input  logic signed [cdde_pkg::SAMPLE_W-1:0]   req_right_in,
   input  logic                                   req_emphasis_on,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cdde_pkg::SAMPLE_W-1:0]   rsp_left_out,
   output logic signed [cdde_pkg::SAMPLE_W-1:0]   rsp_right_out,
   input  logic                                   csr_wr_en,
   input  logic [cdde_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cdde_pkg::COEF_W-1:0]            csr_wdata
);
   import cdde_pkg::*;

   coef_set_type               coef_ff, coef_in;
   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_left_ff, in_right_ff;
   logic                       in_emph_ff;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_left_ff, out_right_ff, out_left_in, out_right_in;
   logic                       was_emph_ff, was_emph_in;
   logic                       accept, advance, clear;
   logic signed [SAMPLE_W-1:0] left_filt, right_filt;

   // Coefficient registers.
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_COEF_B0: coef_in.b0 = $signed(csr_wdata);
            REG_COEF_B1: coef_in.b1 = $signed(csr_wdata);
            REG_COEF_A1: coef_in.a1 = $signed(csr_wdata);
            default:     coef_in    = coef_ff;
         endcase
      end
   end

   // Handshake: the input register moves on when the result register is
   // free or being taken.
   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);
   assign clear        = in_emph_ff != was_emph_ff;
   assign was_emph_in  = advance ? in_emph_ff : was_emph_ff;

   // Result selection: filtered or passed through.
   assign out_left_in  = advance ? (in_emph_ff ? left_filt : in_left_ff) : out_left_ff;
   assign out_right_in = advance ? (in_emph_ff ? right_filt : in_right_ff) : out_right_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0   <= B0_RESET;
         coef_ff.b1   <= B1_RESET;
         coef_ff.a1   <= A1_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         was_emph_ff  <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         was_emph_ff  <= was_emph_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_left_ff  <= req_left_in;
         in_right_ff <= req_right_in;
         in_emph_ff  <= req_emphasis_on;
      end
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   // Channel filters.
   cdde_channel u_left (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .clear (clear),
      .filt  (in_emph_ff),
      .x     (in_left_ff),
      .coef  (coef_ff),
      .y     (left_filt)
   );

   cdde_channel u_right (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .clear (clear),
      .filt  (in_emph_ff),
      .x     (in_right_ff),
      .coef  (coef_ff),
      .y     (right_filt)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

   // An item held in the input register keeps its payload.
   `CDDE_ASSERT_NEXT(a_in_hold, in_valid_ff && !advance, in_valid_ff && $stable(in_left_ff) && $stable(in_emph_ff), "held input item lost or changed")
   // The stored flag follows the item that just moved on.
   `CDDE_ASSERT_NEXT(a_flag_track, advance, was_emph_ff == $past(in_emph_ff), "emphasis flag not tracked")
   // An unflagged item comes out unchanged.
   `CDDE_ASSERT_NEXT(a_pass_through, advance && !in_emph_ff, rsp_left_out == $past(in_left_ff) && rsp_right_out == $past(in_right_ff), "pass-through item altered")

endmodule

// ===== rtl/cdde_channel.sv =====
// ----------------------------------------------------------------------------
// De-emphasis channel filter
// One first-order IIR section with its previous input and previous output
// state. The filtered sample is produced combinationally from the item in
// the input register; state updates when that item moves on.
// ----------------------------------------------------------------------------
module cdde_channel (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  logic                                   clear,
   input  logic                                   filt,
   input  logic signed [cdde_pkg::SAMPLE_W-1:0]   x,
   input  cdde_pkg::coef_set_type                 coef,
   output logic signed [cdde_pkg::SAMPLE_W-1:0]   y
);
   import cdde_pkg::*;

   logic signed [SAMPLE_W-1:0] x1_ff, x1_in, x1_eff;
   logic signed [Y1_W-1:0]     y1_ff, y1_in, y1_eff;
   logic signed [FF_W-2:0]     p0, p1;
   logic signed [FB_W-1:0]     fb;
   logic signed [FF_W-1:0]     ff;
   logic signed [FFSH_W-1:0]   ff_sh;
   logic signed [ACC_W-1:0]    acc;
   logic signed [RND_W-1:0]    acc_x, y_sum, o_sum;
   logic [YR_W-1:0]            y_r;
   logic [OR_W-1:0]            o_r;
   logic [YR_W-Y1_W:0]         y_top;
   logic [OR_W-SAMPLE_W:0]     o_top;
   logic [Y1_W-1:0]            y1_new;

   // A flag change clears the history before this item is filtered.
   assign x1_eff = clear ? '0 : x1_ff;
   assign y1_eff = clear ? '0 : y1_ff;

   // Products and accumulator, exact.
   assign p0    = coef.b0 * x;
   assign p1    = coef.b1 * x1_eff;
   assign fb    = coef.a1 * y1_eff;
   assign ff    = FF_W'(p0) + FF_W'(p1);
   assign ff_sh = FFSH_W'(ff) <<< STATE_FRAC_BITS;
   assign acc   = ACC_W'(ff_sh) - ACC_W'(fb);

   // Round half away from zero: add half, less one when negative, then floor.
   assign acc_x = RND_W'(acc);
   assign y_sum = acc_x + Y_HALF - RND_W'(acc[ACC_W-1]);
   assign o_sum = acc_x + O_HALF - RND_W'(acc[ACC_W-1]);
   assign y_r   = y_sum[RND_W-1:COEF_FRAC_BITS];
   assign o_r   = o_sum[RND_W-1:COEF_FRAC_BITS+STATE_FRAC_BITS];

   // Saturate when the bits above the kept sign are not all equal.
   assign y_top  = y_r[YR_W-1:Y1_W-1];
   assign o_top  = o_r[OR_W-1:SAMPLE_W-1];
   assign y1_new = ((&y_top) || !(|y_top)) ? y_r[Y1_W-1:0]
                 : (y_r[YR_W-1] ? Y1_MIN : Y1_MAX);
   assign y      = ((&o_top) || !(|o_top)) ? o_r[SAMPLE_W-1:0]
                 : (o_r[OR_W-1] ? SMP_MIN : SMP_MAX);

   // Next state: filtered items update history, unfiltered ones keep it (cleared on a flag change).
   always_comb begin
      x1_in = x1_ff;
      y1_in = y1_ff;
      if (step) begin
         if (filt) begin
            x1_in = x;
            y1_in = y1_new;
         end else begin
            x1_in = x1_eff;
            y1_in = y1_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         y1_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
      end
   end

endmodule
